FILE: src/assert_macros.svh
// assertion helpers for the playlist sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/pos_pkg.sv
`default_nettype none
package pos_pkg;
  localparam int unsigned MAX_TRACKS_DEF = 1024;
  localparam int unsigned LFSR_W = 32;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic [2:0] OP_COMMIT = 3'd0;
  localparam logic [2:0] OP_NEXT = 3'd1;
  localparam logic [2:0] OP_PREV = 3'd2;
  localparam logic [2:0] OP_EOT = 3'd3;
  localparam logic [2:0] OP_SHUFFLE = 3'd4;
  localparam logic [2:0] OP_STOP = 3'd5;

  localparam logic [1:0] REG_REPEAT = 2'd0;
  localparam logic [1:0] REG_SEED = 2'd1;

  localparam logic [1:0] RPT_ONE = 2'd1;
  localparam logic [1:0] RPT_ALL = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CUR_RD,      // read entry at current position
    ST_CUR_WAIT,
    ST_FILL,        // write identity
    ST_DRAW,        // advance lfsr, start modulo
    ST_MOD,         // restoring division, one bit per cycle
    ST_SW_RDI,
    ST_SW_RDJ,
    ST_SW_WAIT,
    ST_SW_WRI,
    ST_SW_WRJ,
    ST_FIND_RD,     // search for the saved entry
    ST_FIND_CHK,
    ST_FIX_RDC,
    ST_FIX_WAIT,
    ST_FIX_WRC,
    ST_FIX_WRI,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

FILE: src/pos_if.sv
`default_nettype none
interface pos_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/pos_ram.sv
`default_nettype none
module pos_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: src/playlist_order_sequencer.sv
// Playlist play-order sequencer. Each request (commit, next, previous, end of
// track, set shuffle, stop) gives one response with the playing flag, order
// position, track entry and started flag. Next, previous, stop and end of
// track read the entry at the current position (ST_OUT_RD, ST_OUT_WAIT) and
// register the response; a new request is taken only after it is taken.
// Commit and set shuffle rebuild the order table in one RAM with a single
// read port and a single write port: an identity fill (set shuffle first
// reads the current entry), then for a shuffle a Fisher-Yates pass where each
// of n-1 swaps costs a bit-serial modulo of the LFSR plus the LFSR step and
// RAM traffic, then a linear search of up to n entries and a swap to put the
// current entry back. The shared RAM read port and the serial modulo set how
// long a shuffle takes. The block takes no request while it works.
`default_nettype none
`include "assert_macros.svh"
module playlist_order_sequencer
  import pos_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = MAX_TRACKS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  pos_if.sink       req,
  pos_if.source     rsp,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned AW = $clog2(MAX_TRACKS);
  localparam int unsigned LW = $clog2(MAX_TRACKS + 1);

  // request payload: operation, queue_length, start_position, shuffle_on
  logic [2:0]  operation;
  logic [10:0] queue_length;
  logic [9:0]  start_position;
  logic        shuffle_on;
  assign operation      = req.data[24:22];
  assign queue_length   = req.data[21:11];
  assign start_position = req.data[10:1];
  assign shuffle_on     = req.data[0];

  // architectural state
  logic [1:0]    repeat_mode;
  logic [31:0]   lfsr;
  logic [LW-1:0] len;
  logic [LW-1:0] cur;
  logic          shuf, playing, started;

  // sequencer working registers
  state_t        state, state_next;
  logic          do_shuf;        // run the fisher-yates pass
  logic          have_cur;
  logic [AW-1:0] cur_entry;
  logic [LW-1:0] idx;            // loop index i
  logic [AW-1:0] jdx;
  logic [31:0]   quo;            // dividend shifting out
  logic [LW:0]   rem;            // partial remainder
  logic [5:0]    bitc;
  logic [AW-1:0] tmp_a, tmp_b;

  // table RAM
  logic          we;
  logic [AW-1:0] waddr, raddr, rdata;
  logic [AW-1:0] wdata;
  pos_ram #(.WIDTH(AW), .DEPTH(MAX_TRACKS)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  // response register
  logic          rsp_valid;
  logic [9:0]    rsp_entry;
  assign rsp.valid = rsp_valid;
  assign rsp.data = {playing, 10'(cur), rsp_entry, started};
  assign req.ready = (state == ST_IDLE) && !rsp_valid;

  logic accept;
  assign accept = req.valid && req.ready;

  // shared modulo step: remainder shifted with next dividend bit, less divisor
  logic [LW:0] rem_sh, divisor;
  assign rem_sh  = {rem[LW-1:0], quo[31]};
  assign divisor = (LW+1)'(idx) + (LW+1)'(1);

  logic [31:0] lfsr_adv;
  assign lfsr_adv = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);

  logic [LW-1:0] clen;
  assign clen = (LW'(queue_length) > LW'(MAX_TRACKS) || 32'(queue_length) > MAX_TRACKS)
                ? LW'(MAX_TRACKS) : LW'(queue_length);

  // start position of a commit, zero when out of range
  logic [LW-1:0] cstart;
  assign cstart = (32'(start_position) < 32'(clen)) ? LW'(start_position) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      repeat_mode <= '0; lfsr <= 32'd1; len <= '0; cur <= '0;
      shuf <= 1'b0; playing <= 1'b0; started <= 1'b0; rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_REPEAT[0:0]: repeat_mode <= cfg_data[1:0];
          REG_SEED[0:0]:   lfsr <= (cfg_data == '0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      if (rsp_valid && rsp.ready) rsp_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (operation)
              OP_COMMIT: if (queue_length != '0) begin
                len <= clen;
                cur <= cstart;
                playing <= 1'b1; started <= 1'b1;
                do_shuf <= shuf; idx <= '0;
                // identity order: the start entry equals the start position
                have_cur <= shuf; cur_entry <= AW'(cstart);
              end
              OP_NEXT, OP_PREV, OP_EOT: if (len != '0) begin
                if (operation == OP_EOT && !playing) begin
                end else if (operation == OP_EOT && repeat_mode == RPT_ONE) begin
                  if (cur < len) begin playing <= 1'b1; started <= 1'b1; end
                end else if (operation != OP_PREV) begin
                  if (cur + LW'(1) >= len) begin
                    if (operation == OP_EOT && repeat_mode != RPT_ALL)
                      playing <= 1'b0;
                    else begin cur <= '0; playing <= 1'b1; started <= 1'b1; end
                  end else begin cur <= cur + LW'(1); playing <= 1'b1; started <= 1'b1; end
                end else begin
                  if (cur == '0 || cur > len) cur <= len - LW'(1);
                  else cur <= cur - LW'(1);
                  playing <= 1'b1; started <= 1'b1;
                end
              end
              OP_SHUFFLE: begin
                shuf <= shuffle_on; do_shuf <= shuffle_on; idx <= '0;
              end
              OP_STOP: begin playing <= 1'b0; started <= 1'b0; end
              default: ;
            endcase
          end
        end
        ST_CUR_WAIT: begin
          have_cur <= cur < len;
          cur_entry <= rdata;
        end
        ST_FILL: begin
          // at fill end, prepare the next phase index
          if (idx + LW'(1) == len) idx <= do_shuf ? len - LW'(1) : '0;
          else idx <= idx + LW'(1);
        end
        ST_DRAW: begin
          lfsr <= lfsr_adv; quo <= lfsr_adv; rem <= '0; bitc <= '0;
        end
        ST_MOD: begin
          quo <= quo << 1;
          bitc <= bitc + 6'd1;
          rem <= (rem_sh >= divisor) ? rem_sh - divisor : rem_sh;
          if (bitc == 6'd31)
            jdx <= AW'((rem_sh >= divisor) ? rem_sh - divisor : rem_sh);
        end
        ST_SW_RDJ:  tmp_a <= rdata;          // entry i
        ST_SW_WAIT: tmp_b <= rdata;          // entry j
        ST_SW_WRJ:  idx <= idx - LW'(1);
        ST_FIND_RD: ;
        ST_FIND_CHK: if (rdata != cur_entry) idx <= idx + LW'(1);
        ST_FIX_WAIT: tmp_a <= rdata;
        ST_OUT_WAIT: begin
          rsp_entry <= (cur < len) ? 10'(rdata) : '0;
          rsp_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // next state and RAM control
  always_comb begin
    state_next = state;
    we = 1'b0; waddr = AW'(idx); wdata = AW'(idx); raddr = AW'(cur);
    case (state)
      ST_IDLE: if (accept) begin
        if (operation == OP_COMMIT && queue_length != '0) state_next = ST_FILL;
        else if (operation == OP_SHUFFLE)
          state_next = (len == '0) ? ST_OUT_RD : ST_CUR_RD;
        else state_next = ST_OUT_RD;
      end
      ST_CUR_RD: begin raddr = AW'(cur); state_next = ST_CUR_WAIT; end
      ST_CUR_WAIT: state_next = ST_FILL;
      ST_FILL: begin
        we = 1'b1;
        if (idx + LW'(1) == len)
          state_next = (do_shuf && len > LW'(1)) ? ST_DRAW
                     : (have_cur ? ST_FIND_RD : ST_OUT_RD);
      end
      ST_DRAW: state_next = ST_MOD;
      ST_MOD: if (bitc == 6'd31) state_next = ST_SW_RDI;
      ST_SW_RDI: begin raddr = AW'(idx); state_next = ST_SW_RDJ; end
      ST_SW_RDJ: begin raddr = jdx; state_next = ST_SW_WAIT; end
      ST_SW_WAIT: state_next = ST_SW_WRI;
      ST_SW_WRI: begin
        we = 1'b1; waddr = AW'(idx); wdata = tmp_b; state_next = ST_SW_WRJ;
      end
      ST_SW_WRJ: begin
        we = 1'b1; waddr = jdx; wdata = tmp_a;
        state_next = (idx == LW'(1)) ? (have_cur ? ST_FIND_RD : ST_OUT_RD) : ST_DRAW;
      end
      ST_FIND_RD: begin raddr = AW'(idx); state_next = ST_FIND_CHK; end
      ST_FIND_CHK: begin
        if (rdata == cur_entry) state_next = ST_FIX_RDC;
        else state_next = (idx + LW'(1) >= len) ? ST_OUT_RD : ST_FIND_RD;
      end
      ST_FIX_RDC: begin raddr = AW'(cur); state_next = ST_FIX_WAIT; end
      ST_FIX_WAIT: state_next = ST_FIX_WRC;
      ST_FIX_WRC: begin
        we = 1'b1; waddr = AW'(cur); wdata = cur_entry; state_next = ST_FIX_WRI;
      end
      ST_FIX_WRI: begin
        we = 1'b1; waddr = AW'(idx); wdata = tmp_a; state_next = ST_OUT_RD;
      end
      ST_OUT_RD: begin raddr = AW'(cur); state_next = ST_OUT_WAIT; end
      ST_OUT_WAIT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_busy_not_ready, clk, rst, state != ST_IDLE, !req.ready, "ready while busy")
  `ASSERT_IMPL(a_cur_range, clk, rst, len != '0, cur < len, "position beyond queue")
  `ASSERT_NEXT(a_mod_range, clk, rst, state == ST_MOD && bitc == 6'd31,
               LW'(jdx) <= idx, "swap index above i")
endmodule
`default_nettype wire
